// File: rtl/wlpd_pkg.sv
// Package for the weather loop packet decoder: record type, status codes,
// packet constants and helper functions. No dependencies.
package wlpd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 7;
    localparam int unsigned NUM_SLOTS   = 16;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned SHORT_LEN   = 17;
    localparam int unsigned SHORT_CAP   = 12;
    localparam int unsigned LONG_LEN    = 99;
    localparam int unsigned HDR_LEN     = 5;
    localparam int unsigned WIND_Y_W    = 19;
    localparam int unsigned WIND_W      = 15;
    localparam int unsigned RAIN_W      = 24;
    localparam int unsigned TDATA_W     = 144;

    localparam logic [BYTE_W-1:0] SHORT_START = 8'h01;

    // mph -> m/s Q8: (mph*357632 + 1562) / 3125
    //   = mph*114 + (mph*1382 + 1562) / 3125, the last by reciprocal 2^31
    localparam int unsigned WIND_INT    = 114;
    localparam int unsigned WIND_FRAC   = 1382;
    localparam int unsigned WIND_ROUND  = 1562;
    localparam int unsigned WIND_RECIP  = 687195;
    localparam int unsigned WIND_SHIFT  = 31;
    localparam int unsigned RECIP_W     = 20;

    localparam int unsigned RAIN_SHORT_MUL = 20;
    localparam int unsigned RAIN_LONG_MUL  = 254;

    // wind byte positions within a packet
    localparam logic [POS_W-1:0] SHORT_WIND_POS = 7'd4;
    localparam logic [POS_W-1:0] LONG_WIND_POS  = 7'd14;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_START  = 2'd1,
        ST_BAD_HEADER = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [15:0]          temp_inside_tenths;
        logic [15:0]          temp_outside_tenths;
        logic [7:0]           humidity_indoor;
        logic [7:0]           humidity_outside;
        logic [15:0]          pressure_thousandths;
        logic [WIND_W-1:0]    wind_speed_q8;
        logic [15:0]          wind_direction;
        logic [RAIN_W-1:0]    rain_hundredths;
        logic [7:0]           uv_tenths;
        logic [15:0]          solar_radiation;
    } record_t;

    function automatic logic [BYTE_W-1:0] loop_hdr_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h4C;
            3'd1:    b = 8'h4F;
            3'd2:    b = 8'h4F;
            3'd3:    b = 8'h50;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/wlpd_in_reg.sv
// Input register of the decoder: holds one received byte until the core takes it.
// Depends on wlpd_pkg.
module wlpd_in_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [wlpd_pkg::BYTE_W-1:0] s_tdata,
    input  logic                       take,
    output logic                       valid,
    output logic [wlpd_pkg::BYTE_W-1:0] data
);
    import wlpd_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    assign s_tready = !valid_reg || take;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

endmodule

// File: rtl/wlpd_core.sv
// Packet tracking, byte capture and record formation.
// Depends on wlpd_pkg.
module wlpd_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       step,
    input  logic [wlpd_pkg::BYTE_W-1:0] rx_byte,
    output logic                       fire,
    output wlpd_pkg::record_t          rec
);
    import wlpd_pkg::*;

    logic                  fmt_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  await_reg, await_next;
    logic                  hdr_ok_reg, hdr_ok_next;
    logic [BYTE_W-1:0]     cap_reg  [NUM_SLOTS];
    logic [BYTE_W-1:0]     cap_next [NUM_SLOTS];
    logic [WIND_Y_W-1:0]   wind_y_reg, wind_y_next;

    logic [POS_W-1:0]      pos_inc;
    logic                  cap_en;
    logic [SLOT_W-1:0]     cap_idx;
    logic                  status_ok;
    status_t               status_sel;

    logic [WIND_Y_W+RECIP_W-1:0] wind_prod;
    logic [WIND_W-1:0]           wind_q8;
    logic [BYTE_W-1:0]           wind_mph;
    record_t                     rec_ok;

    assign pos_inc = pos_reg + 7'd1;

    always_comb
    begin
        pos_next    = pos_reg;
        await_next  = await_reg;
        hdr_ok_next = hdr_ok_reg;
        wind_y_next = wind_y_reg;
        cap_en      = 1'b0;
        cap_idx     = '0;
        fire        = 1'b0;
        status_ok   = 1'b0;
        status_sel  = ST_OK;
        if (cfg_we)
        begin
            pos_next    = '0;
            await_next  = 1'b1;
            hdr_ok_next = 1'b1;
        end
        else if (step)
        begin
            if (!fmt_reg)
            begin
                if (await_reg)
                begin
                    if (rx_byte == SHORT_START)
                    begin
                        await_next = 1'b0;
                        pos_next   = '0;
                    end
                    else
                    begin
                        fire       = 1'b1;
                        status_sel = ST_BAD_START;
                    end
                end
                else
                begin
                    if (pos_reg < POS_W'(SHORT_CAP))
                    begin
                        cap_en  = 1'b1;
                        cap_idx = pos_reg[SLOT_W-1:0];
                    end
                    if (pos_reg == SHORT_WIND_POS)
                    begin
                        wind_y_next = WIND_Y_W'(rx_byte * WIND_Y_W'(WIND_FRAC))
                                    + WIND_Y_W'(WIND_ROUND);
                    end
                    if (pos_inc == POS_W'(SHORT_LEN))
                    begin
                        pos_next   = '0;
                        await_next = 1'b1;
                        fire       = 1'b1;
                        status_ok  = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
            end
            else
            begin
                if (pos_reg < POS_W'(HDR_LEN) && rx_byte != loop_hdr_byte(pos_reg[2:0]))
                begin
                    hdr_ok_next = 1'b0;
                end
                case (pos_reg)
                    7'd7, 7'd8, 7'd9, 7'd10, 7'd11, 7'd12, 7'd13, 7'd14:
                    begin
                        cap_en  = 1'b1;
                        cap_idx = SLOT_W'(pos_reg - 7'd7);
                    end
                    7'd16:   begin cap_en = 1'b1; cap_idx = 4'd8;  end
                    7'd17:   begin cap_en = 1'b1; cap_idx = 4'd9;  end
                    7'd33:   begin cap_en = 1'b1; cap_idx = 4'd10; end
                    7'd43:   begin cap_en = 1'b1; cap_idx = 4'd11; end
                    7'd44:   begin cap_en = 1'b1; cap_idx = 4'd12; end
                    7'd45:   begin cap_en = 1'b1; cap_idx = 4'd13; end
                    7'd50:   begin cap_en = 1'b1; cap_idx = 4'd14; end
                    7'd51:   begin cap_en = 1'b1; cap_idx = 4'd15; end
                    default: cap_en = 1'b0;
                endcase
                if (pos_reg == LONG_WIND_POS)
                begin
                    wind_y_next = WIND_Y_W'(rx_byte * WIND_Y_W'(WIND_FRAC))
                                + WIND_Y_W'(WIND_ROUND);
                end
                if (pos_inc == POS_W'(LONG_LEN))
                begin
                    pos_next    = '0;
                    hdr_ok_next = 1'b1;
                    fire        = 1'b1;
                    if (hdr_ok_reg)
                    begin
                        status_ok = 1'b1;
                    end
                    else
                    begin
                        status_sel = ST_BAD_HEADER;
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cap_next[i] = cap_reg[i];
        end
        if (cap_en)
        begin
            cap_next[cap_idx] = rx_byte;
        end
    end

    // record fields from captured bytes; final byte of a packet is never captured
    assign wind_mph  = fmt_reg ? cap_reg[7] : cap_reg[4];
    assign wind_prod = wind_y_reg * RECIP_W'(WIND_RECIP);
    assign wind_q8   = WIND_W'(wind_mph * WIND_W'(WIND_INT))
                     + WIND_W'(wind_prod >> WIND_SHIFT);

    always_comb
    begin
        rec_ok.status        = ST_OK;
        rec_ok.wind_speed_q8 = wind_q8;
        if (!fmt_reg)
        begin
            rec_ok.temp_inside_tenths   = {cap_reg[1], cap_reg[0]};
            rec_ok.temp_outside_tenths  = {cap_reg[3], cap_reg[2]};
            rec_ok.humidity_indoor      = cap_reg[9];
            rec_ok.humidity_outside     = cap_reg[10];
            rec_ok.pressure_thousandths = {cap_reg[8], cap_reg[7]};
            rec_ok.wind_direction       = {cap_reg[6], cap_reg[5]};
            rec_ok.rain_hundredths      = RAIN_W'(cap_reg[11]) * RAIN_W'(RAIN_SHORT_MUL);
            rec_ok.uv_tenths            = '0;
            rec_ok.solar_radiation      = '0;
        end
        else
        begin
            rec_ok.temp_inside_tenths   = {cap_reg[3], cap_reg[2]};
            rec_ok.temp_outside_tenths  = {cap_reg[6], cap_reg[5]};
            rec_ok.humidity_indoor      = cap_reg[4];
            rec_ok.humidity_outside     = cap_reg[10];
            rec_ok.pressure_thousandths = {cap_reg[1], cap_reg[0]};
            rec_ok.wind_direction       = {cap_reg[9], cap_reg[8]};
            rec_ok.rain_hundredths      = RAIN_W'({cap_reg[15], cap_reg[14]})
                                        * RAIN_W'(RAIN_LONG_MUL);
            rec_ok.uv_tenths            = cap_reg[11];
            rec_ok.solar_radiation      = {cap_reg[13], cap_reg[12]};
        end
    end

    always_comb
    begin
        if (status_ok)
        begin
            rec = rec_ok;
        end
        else
        begin
            rec        = '0;
            rec.status = status_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= 1'b0;
            pos_reg    <= '0;
            await_reg  <= 1'b1;
            hdr_ok_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg <= cfg_wdata;
            end
            pos_reg    <= pos_next;
            await_reg  <= await_next;
            hdr_ok_reg <= hdr_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wind_y_reg <= wind_y_next;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cap_reg[i] <= cap_next[i];
        end
    end

`ifndef NO_ASSERTIONS
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (pos_reg == '0) && await_reg && hdr_ok_reg)
        else $error("packet state not restarted after format write");

    a_pos_long: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(LONG_LEN))
        else $error("byte position past long packet length");

    a_pos_short: assert property (@(posedge clk) disable iff (!rst_n)
        !fmt_reg |-> pos_reg < POS_W'(SHORT_LEN))
        else $error("byte position past short packet length");

    a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && rec.status == ST_BAD_START) |-> (!fmt_reg && await_reg))
        else $error("bad start reported outside start hunt");

    a_hdr_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && fmt_reg) |=> hdr_ok_reg && pos_reg == '0)
        else $error("header flag or position not restored after long packet");
`endif

endmodule

// File: rtl/wlpd_out_reg.sv
// Result register of the decoder: holds one record until the receiver takes it.
// Depends on wlpd_pkg.
module wlpd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  wlpd_pkg::record_t rec,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output wlpd_pkg::record_t rec_out
);
    import wlpd_pkg::*;

    logic    valid_reg;
    record_t rec_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign rec_out  = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            rec_reg <= rec;
        end
    end

endmodule

// File: rtl/weather_loop_packet_decoder.sv
// Weather loop packet decoder, top level: input register, packet core, result register.
// Depends on wlpd_pkg, wlpd_in_reg, wlpd_core, wlpd_out_reg.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one received link byte per transfer.
//   m_tvalid/m_tready/m_tdata/m_tuser carry one decoded record per transfer;
//   m_tuser is the status (decoded, bad start byte, bad LOOP header).
//   cfg_we/cfg_wdata write the format register (0 short, 1 long) and abandon
//   any partial packet; write only while the block is idle.
//   Throughput: one byte per cycle while the result register is free. A byte
//   that completes a packet (or a bad start byte) passes the input register,
//   and its record is then loaded into the result register, which raises m_tvalid.
//   Reset: short format, hunting for the start byte, both registers empty.
//   While a record waits on m_tready, one more byte is held in the input
//   register and s_tready then drops until the record is taken.
module weather_loop_packet_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wlpd_pkg::BYTE_W-1:0]    s_tdata,    // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] temp_inside_tenths, [31:16] temp_outside_tenths,
    // [39:32] humidity_indoor, [47:40] humidity_outside,
    // [63:48] pressure_thousandths, [78:64] wind_speed_q8,
    // [94:79] wind_direction, [118:95] rain_hundredths,
    // [126:119] uv_tenths, [142:127] solar_radiation, [143] zero
    output logic [wlpd_pkg::TDATA_W-1:0]   m_tdata,
    output logic [1:0]                     m_tuser,    // [1:0] status
    input  logic                           cfg_we,
    input  logic                           cfg_wdata   // station_format
);
    import wlpd_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_data;
    logic              out_free;
    logic              step;
    logic              fire;
    record_t           rec;
    record_t           rec_out;

    assign step = in_valid && out_free;

    wlpd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (step),
        .valid    (in_valid),
        .data     (in_data)
    );

    wlpd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .rx_byte   (in_data),
        .fire      (fire),
        .rec       (rec)
    );

    wlpd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .rec      (rec),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .rec_out  (rec_out)
    );

    assign m_tuser = rec_out.status;
    assign m_tdata = {1'b0,
                      rec_out.solar_radiation,
                      rec_out.uv_tenths,
                      rec_out.rain_hundredths,
                      rec_out.wind_direction,
                      rec_out.wind_speed_q8,
                      rec_out.pressure_thousandths,
                      rec_out.humidity_outside,
                      rec_out.humidity_indoor,
                      rec_out.temp_outside_tenths,
                      rec_out.temp_inside_tenths};

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for weather_loop_packet_decoder: streams link bytes in both
// packet formats, decodes them in a local model and checks every record.
// Depends on wlpd_pkg and the decoder RTL.
module tb_top;
    import wlpd_pkg::*;

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CALM_FROM   = 1000;
    localparam int unsigned CALM_TO     = 1500;
    localparam int unsigned SETTLE      = 8;

    localparam logic [7:0] LOOP_HDR [5] = '{8'h4C, 8'h4F, 8'h4F, 8'h50, 8'h00};
    localparam logic [6:0] LONG_SLOT_POS [16] = '{7'd7, 7'd8, 7'd9, 7'd10, 7'd11, 7'd12,
        7'd13, 7'd14, 7'd16, 7'd17, 7'd33, 7'd43, 7'd44, 7'd45, 7'd50, 7'd51};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_we = 1'b0;
    logic                 cfg_wdata = 1'b0;

    logic [7:0]  link_bytes [$];
    record_t     pending_records [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          byte_xfer = 1'b0;
    bit          hold_req = 1'b0;

    // decoder model state
    bit          fmt_long = 1'b0;
    logic [6:0]  byte_pos = '0;
    bit          hunting = 1'b1;
    bit          hdr_good = 1'b1;
    logic [7:0]  slot [16];

    weather_loop_packet_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic logic [WIND_W-1:0] mph_to_q8(input logic [7:0] mph);
        longint unsigned t;
        t = (longint'(mph) * 357632 + 1562) / 3125;
        return t[WIND_W-1:0];
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        case ($urandom_range(9))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    function automatic bit side_idles();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < 9;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        record_t r;
        r = '0;
        if (!fmt_long)
        begin
            if (hunting)
            begin
                if (b == SHORT_START)
                begin
                    hunting = 1'b0;
                    byte_pos = '0;
                end
                else
                begin
                    r.status = ST_BAD_START;
                    pending_records.push_back(r);
                end
            end
            else
            begin
                if (byte_pos < 12)
                    slot[byte_pos[3:0]] = b;
                byte_pos = byte_pos + 7'd1;
                if (byte_pos == 7'd17)
                begin
                    byte_pos = '0;
                    hunting = 1'b1;
                    r.status               = ST_OK;
                    r.temp_inside_tenths   = {slot[1], slot[0]};
                    r.temp_outside_tenths  = {slot[3], slot[2]};
                    r.humidity_indoor      = slot[9];
                    r.humidity_outside     = slot[10];
                    r.pressure_thousandths = {slot[8], slot[7]};
                    r.wind_speed_q8        = mph_to_q8(slot[4]);
                    r.wind_direction       = {slot[6], slot[5]};
                    r.rain_hundredths      = 24'(slot[11]) * 24'd20;
                    pending_records.push_back(r);
                end
            end
        end
        else
        begin
            if (byte_pos < 5 && b != LOOP_HDR[byte_pos])
                hdr_good = 1'b0;
            for (int k = 0; k < 16; k++)
                if (LONG_SLOT_POS[k] == byte_pos)
                    slot[k] = b;
            byte_pos = byte_pos + 7'd1;
            if (byte_pos == 7'd99)
            begin
                byte_pos = '0;
                if (!hdr_good)
                begin
                    hdr_good = 1'b1;
                    r.status = ST_BAD_HEADER;
                end
                else
                begin
                    r.status               = ST_OK;
                    r.temp_inside_tenths   = {slot[3], slot[2]};
                    r.temp_outside_tenths  = {slot[6], slot[5]};
                    r.humidity_indoor      = slot[4];
                    r.humidity_outside     = slot[10];
                    r.pressure_thousandths = {slot[1], slot[0]};
                    r.wind_speed_q8        = mph_to_q8(slot[7]);
                    r.wind_direction       = {slot[9], slot[8]};
                    r.rain_hundredths      = 24'({slot[15], slot[14]}) * 24'd254;
                    r.uv_tenths            = slot[11];
                    r.solar_radiation      = {slot[13], slot[12]};
                end
                pending_records.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic check_record(input record_t e);
        check_field("status", 32'(e.status), 32'(m_tuser));
        check_field("temp_inside_tenths", 32'(e.temp_inside_tenths), 32'(m_tdata[15:0]));
        check_field("temp_outside_tenths", 32'(e.temp_outside_tenths), 32'(m_tdata[31:16]));
        check_field("humidity_indoor", 32'(e.humidity_indoor), 32'(m_tdata[39:32]));
        check_field("humidity_outside", 32'(e.humidity_outside), 32'(m_tdata[47:40]));
        check_field("pressure_thousandths", 32'(e.pressure_thousandths), 32'(m_tdata[63:48]));
        check_field("wind_speed_q8", 32'(e.wind_speed_q8), 32'(m_tdata[78:64]));
        check_field("wind_direction", 32'(e.wind_direction), 32'(m_tdata[94:79]));
        check_field("rain_hundredths", 32'(e.rain_hundredths), 32'(m_tdata[118:95]));
        check_field("uv_tenths", 32'(e.uv_tenths), 32'(m_tdata[126:119]));
        check_field("solar_radiation", 32'(e.solar_radiation), 32'(m_tdata[142:127]));
        check_field("tdata pad", 32'd0, 32'(m_tdata[143]));
    endtask

    // monitor: format writes, accepted bytes, delivered records
    always @(posedge clk)
    begin
        if (!rst_n)
            byte_xfer = 1'b0;
        else
        begin
            cycle_count++;
            byte_xfer = s_tvalid && s_tready;
            if (cfg_we)
            begin
                fmt_long = cfg_wdata;
                byte_pos = '0;
                hunting  = 1'b1;
                hdr_good = 1'b1;
            end
            if (byte_xfer)
                decode_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (pending_records.size() == 0)
                begin
                    $display("%0t ns: unexpected record, expected none actual status %0h tdata %0h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                    check_record(pending_records.pop_front());
            end
        end
    end

    // byte driver
    always @(negedge clk)
    begin
        if (!s_tvalid || byte_xfer)
        begin
            if (link_bytes.size() > 0 && !side_idles())
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= link_bytes.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // record receiver, with one long hold-off
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !side_idles();
    end

    task automatic drain_decoder();
        do
            @(posedge clk);
        while (link_bytes.size() != 0 || s_tvalid || pending_records.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_format(input bit fmt);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic push_short_packet();
        link_bytes.push_back(SHORT_START);
        repeat (17) link_bytes.push_back(rand_byte());
    endtask

    task automatic push_long_packet(input int unsigned fill);
        int unsigned bad_idx;
        logic [7:0]  b;
        bad_idx = $urandom_range(4);
        for (int i = 0; i < 99; i++)
        begin
            if (i < 5)
            begin
                b = LOOP_HDR[i];
                if (fill == 3 && i == bad_idx)
                    b = LOOP_HDR[i] ^ 8'($urandom_range(1, 255));
            end
            else
                case (fill)
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = rand_byte();
                endcase
            link_bytes.push_back(b);
        end
    endtask

    task automatic push_short_traffic(input int unsigned rounds);
        repeat (rounds)
        begin
            if ($urandom_range(99) < 80)
                push_short_packet();
            else
                repeat ($urandom_range(1, 4)) link_bytes.push_back(rand_byte());
        end
    endtask

    task automatic push_long_traffic(input int unsigned count);
        repeat (count)
        begin
            case ($urandom_range(9))
                0, 1:    push_long_packet(3);
                2:       repeat (99) link_bytes.push_back(rand_byte());
                default: push_long_packet(2);
            endcase
        end
    endtask

    initial
    begin
        foreach (slot[i]) slot[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short format: bad start bytes, a full-scale packet, an abandoned one
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'hFE);
        link_bytes.push_back(8'hFF);
        link_bytes.push_back(SHORT_START);
        repeat (17) link_bytes.push_back(8'hFF);
        link_bytes.push_back(SHORT_START);
        repeat (3) link_bytes.push_back(8'h00);
        drain_decoder();
        write_format(1'b1);

        // long format: all-zero and all-ones payloads, a bad header, random ones
        push_long_packet(0);
        push_long_packet(1);
        push_long_packet(3);
        push_long_traffic(2);
        repeat (40) link_bytes.push_back(rand_byte());
        drain_decoder();
        write_format(1'b0);

        hold_req = 1'b1;
        push_short_traffic(30);
        link_bytes.push_back(SHORT_START);
        repeat (5) link_bytes.push_back(rand_byte());
        drain_decoder();
        write_format(1'b0);

        push_short_traffic(10);
        drain_decoder();
        write_format(1'b1);

        push_long_traffic(3);
        drain_decoder();

        if (mismatches == 0 && pending_records.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
